/* rtl/gcr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types and constants for the glyph column reveal mask.
// ----------------------------------------------------------------------------
package gcr_pkg;

    localparam int GCR_MAX_WIDTH       = 256;
    localparam int GCR_MAX_HEIGHT      = 256;
    localparam int GCR_ALPHA_THRESHOLD = 8;

    // Q10 reveal value at or above which every group stays visible
    localparam logic [10:0] REVEAL_SHOW_ALL = 11'd1023;

    // request function codes
    typedef enum logic [1:0] {
        FN_CLEAR  = 2'd0,
        FN_WRITE  = 2'd1,
        FN_FINISH = 2'd2,
        FN_READ   = 2'd3
    } func_t;

    // configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_REVEAL_FRACTION = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WALK,
        ST_CALC
    } state_t;

    // controls from the top level sequencer to the segmentation unit
    typedef struct packed {
        logic clear;       // clear all column marks
        logic mark;        // set mark of the addressed column
        logic walk_start;  // reset run counters before a column walk
        logic walk;        // one column processed this cycle
        logic calc;        // latch run count and visible count
        logic rd_en;       // read run number of the addressed column
    } seg_ctrl_t;

endpackage : gcr_pkg
`default_nettype wire

/* rtl/gcr_frame_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gcr_frame_mem
// Single-port frame memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module gcr_frame_mem
    import gcr_pkg::*;
#(
    parameter int DEPTH = GCR_MAX_WIDTH * GCR_MAX_HEIGHT,
    parameter int AW    = $clog2(GCR_MAX_WIDTH * GCR_MAX_HEIGHT)
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic          re,
    input  wire logic [AW-1:0] addr,
    input  wire logic [31:0]   wdata,
    output logic      [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule : gcr_frame_mem
`default_nettype wire

/* rtl/gcr_seg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gcr_seg
// Column marks, left-to-right run walk into the run table memory, run and
// visible counts, and the per-column hide decision for reads.
// ----------------------------------------------------------------------------
module gcr_seg
    import gcr_pkg::*;
#(
    parameter int MAX_WIDTH = GCR_MAX_WIDTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire seg_ctrl_t  ctrl,
    input  wire logic [7:0] col,            // column for mark and read
    input  wire logic [8:0] image_width,
    input  wire logic [10:0] reveal_fraction,
    output logic            walk_last,
    output logic            hide_col,       // valid the cycle after rd_en
    output logic [7:0]      run_total,
    output logic [7:0]      run_shown,
    output logic            changed
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int PW = CW + 10;

    logic [MAX_WIDTH-1:0] marks_reg;
    logic [XW-1:0]        walk_x_reg;
    logic                 in_run_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        run_reg;
    logic [CW-1:0]        shown_reg;
    logic [CW-1:0]        shown_next;
    logic [PW-1:0]        prod;
    logic                 col_hit;
    logic [CW-1:0]        idx;
    logic [CW:0]          run_mem [MAX_WIDTH];   // {valid, run number}
    logic [CW:0]          rd_run_reg;
    logic [XW-1:0]        col_x;

    assign col_x = XW'(col);

    // column belongs to a run if in use and marked
    assign col_hit   = (32'(walk_x_reg) < 32'(image_width)) && marks_reg[walk_x_reg];
    assign idx       = in_run_reg ? (count_reg - 1'b1) : count_reg;
    assign count_next = (col_hit && !in_run_reg) ? (count_reg + 1'b1) : count_reg;
    assign walk_last = (walk_x_reg == XW'(MAX_WIDTH - 1));

    assign prod = PW'(count_reg) * PW'(reveal_fraction[9:0]);
    assign shown_next = (reveal_fraction >= REVEAL_SHOW_ALL) ? count_reg : CW'(prod >> 10);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg  <= '0;
            walk_x_reg <= '0;
            in_run_reg <= 1'b0;
            count_reg  <= '0;
            run_reg    <= '0;
            shown_reg  <= '0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                marks_reg <= '0;
            end
            else if (ctrl.mark)
            begin
                marks_reg[col_x] <= 1'b1;
            end

            if (ctrl.walk_start)
            begin
                walk_x_reg <= '0;
                in_run_reg <= 1'b0;
                count_reg  <= '0;
            end
            else if (ctrl.walk)
            begin
                walk_x_reg <= walk_x_reg + 1'b1;
                in_run_reg <= col_hit;
                count_reg  <= count_next;
            end

            if (ctrl.calc)
            begin
                run_reg   <= count_reg;
                shown_reg <= shown_next;
            end
        end
    end

    // run table: written once per column during the walk, read for pixel reads
    always_ff @(posedge clk)
    begin
        if (ctrl.walk)
        begin
            run_mem[walk_x_reg] <= {col_hit, idx};
        end
        if (ctrl.rd_en)
        begin
            rd_run_reg <= run_mem[col_x];
        end
    end

    assign changed   = (shown_reg < run_reg);
    // every numbered run is below run_reg, so nothing hides unless changed
    assign hide_col  = changed && rd_run_reg[CW] && (rd_run_reg[CW-1:0] >= shown_reg);
    assign run_total = 8'(run_reg);
    assign run_shown = 8'(shown_reg);

endmodule : gcr_seg
`default_nettype wire

/* rtl/glyph_column_reveal_mask.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_column_reveal_mask
// Frame store with column segmentation; hides opaque pixels of trailing
// glyph groups on read.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  item     | item_valid / item_stall   | func, pos_x, pos_y, pixel_in
//  result   | result_valid/result_stall | pixel_out, group_total,
//           |                           | groups_shown, frame_changed,
//           |                           | bad_position
//  config   | cfg_we                    | cfg_index, cfg_data
//
//  Clear, write and out-of-range requests: result loaded at the accept edge.
//  Read: result follows the registered read of the frame and run memories.
//  Finish: run walk of all MAX_WIDTH columns, one column per cycle.
//  One request in flight; a new one is taken while the last result is taken.
//  Reset clears marks and counts and presets config; frame memory is not cleared.
//  A stalled result holds every output field.
// ----------------------------------------------------------------------------
module glyph_column_reveal_mask
    import gcr_pkg::*;
#(
    parameter int MAX_WIDTH       = GCR_MAX_WIDTH,
    parameter int MAX_HEIGHT      = GCR_MAX_HEIGHT,
    parameter int ALPHA_THRESHOLD = GCR_ALPHA_THRESHOLD
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    // request
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  pos_x,
    input  wire logic [7:0]  pos_y,
    input  wire logic [31:0] pixel_in,
    // result
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [31:0]      pixel_out,
    output logic [7:0]       group_total,
    output logic [7:0]       groups_shown,
    output logic             frame_changed,
    output logic             bad_position
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    state_t      state_reg, state_next;
    seg_ctrl_t   ctrl;

    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [10:0] reveal_reg;

    logic        result_valid_reg, result_valid_next;
    logic [31:0] pixel_out_reg, pixel_out_next;
    logic        bad_reg, bad_next;
    logic        out_load;

    logic        accept;
    logic        out_free;
    logic        pos_bad;
    logic        opaque_in;
    logic        opaque_rd;
    logic        mem_we;
    logic        mem_re;
    logic [AW-1:0] addr;
    logic [31:0] rdata;
    logic        walk_last;
    logic        hide_col;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            reveal_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:     width_reg  <= cfg_data[8:0];
                CFG_IMAGE_HEIGHT:    height_reg <= cfg_data[8:0];
                CFG_REVEAL_FRACTION: reveal_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // ---------------- request decode ----------------
    assign out_free   = !result_valid_reg || !result_stall;
    assign item_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept     = item_valid && !item_stall;

    // size in use is the configured size saturated at the memory size
    assign pos_bad = ({1'b0, pos_x} >= width_reg) || (32'(pos_x) >= MAX_WIDTH)
                  || ({1'b0, pos_y} >= height_reg) || (32'(pos_y) >= MAX_HEIGHT);

    assign addr      = AW'(32'(pos_y) * 32'(MAX_WIDTH) + 32'(pos_x));
    assign opaque_in = (32'(pixel_in[31:24]) > ALPHA_THRESHOLD);
    assign opaque_rd = (32'(rdata[31:24]) > ALPHA_THRESHOLD);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next      = state_reg;
        ctrl            = '0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        out_load        = 1'b0;
        pixel_out_next  = 32'd0;
        bad_next        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FN_CLEAR:
                        begin
                            ctrl.clear = 1'b1;
                            out_load   = 1'b1;
                        end
                        FN_WRITE:
                        begin
                            out_load = 1'b1;
                            bad_next = pos_bad;
                            if (!pos_bad)
                            begin
                                mem_we    = 1'b1;
                                ctrl.mark = opaque_in;
                            end
                        end
                        FN_FINISH:
                        begin
                            ctrl.walk_start = 1'b1;
                            state_next      = ST_WALK;
                        end
                        FN_READ:
                        begin
                            if (pos_bad)
                            begin
                                out_load = 1'b1;
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                ctrl.rd_en = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                // read data stays in the memory output registers until taken
                if (out_free)
                begin
                    out_load       = 1'b1;
                    pixel_out_next = (hide_col && opaque_rd) ? 32'd0 : rdata;
                    state_next     = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                ctrl.walk = 1'b1;
                if (walk_last)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                // status changes together with loading the finish result
                if (out_free)
                begin
                    ctrl.calc  = 1'b1;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid_next = out_load ? 1'b1 : (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pixel_out_reg <= pixel_out_next;
            bad_reg       <= bad_next;
        end
    end

    // ---------------- units ----------------
    gcr_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_frame_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (addr),
        .wdata (pixel_in),
        .rdata (rdata)
    );

    gcr_seg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seg (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .col             (pos_x),
        .image_width     (width_reg),
        .reveal_fraction (reveal_reg),
        .walk_last       (walk_last),
        .hide_col        (hide_col),
        .run_total       (group_total),
        .run_shown       (groups_shown),
        .changed         (frame_changed)
    );

    assign result_valid = result_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign bad_position = bad_reg;

endmodule : glyph_column_reveal_mask
`default_nettype wire

/* rtl/gcr_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gcr_checker
// Port-level checks for the glyph column reveal mask, bound to the top level.
// ----------------------------------------------------------------------------
module gcr_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_stall,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic [31:0] pixel_out,
    input wire logic [7:0]  group_total,
    input wire logic [7:0]  groups_shown,
    input wire logic        frame_changed,
    input wire logic        bad_position
);

    // a held result and a new request never complete together
    a_no_take_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |-> !(result_valid && result_stall))
        else $error("request taken while result held");

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && bad_position |-> pixel_out == 32'd0)
        else $error("out-of-range request returned a pixel");

    a_status_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(group_total) && $stable(groups_shown)
            && $stable(frame_changed))
        else $error("status changed under a held result");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(pixel_out)
            && $stable(bad_position))
        else $error("held result dropped or changed");

endmodule : gcr_checker

bind glyph_column_reveal_mask gcr_checker u_gcr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .pixel_out     (pixel_out),
    .group_total   (group_total),
    .groups_shown  (groups_shown),
    .frame_changed (frame_changed),
    .bad_position  (bad_position)
);
`default_nettype wire

/* tb/sv/glyph_reveal_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_reveal_monitor
// Watches the config port and the request and result channels of the reveal mask. It
// keeps its own copy of the frame, column marks and run numbering, predicts
// the result of every accepted request and compares the results field by
// field.
// ----------------------------------------------------------------------------
module glyph_reveal_monitor
    import gcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  pos_x,
    input  logic [7:0]  pos_y,
    input  logic [31:0] pixel_in,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [31:0] pixel_out,
    input  logic [7:0]  group_total,
    input  logic [7:0]  groups_shown,
    input  logic        frame_changed,
    input  logic        bad_position,
    output int          mismatch_count,
    output int          outstanding
);

    typedef struct packed {
        logic [31:0] pixel;
        logic [7:0]  total;
        logic [7:0]  shown;
        logic        changed;
        logic        bad;
    } reveal_result_t;

    reveal_result_t expected_results[$];

    logic [31:0] frame_copy [0:GCR_MAX_WIDTH*GCR_MAX_HEIGHT-1];
    bit          column_marked [0:GCR_MAX_WIDTH-1];
    bit          column_in_run [0:GCR_MAX_WIDTH-1];
    logic [7:0]  column_run [0:GCR_MAX_WIDTH-1];
    int unsigned run_total;
    int unsigned runs_visible;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [10:0] reveal_reg;

    // Left to right column walk; numbers maximal runs of marked columns.
    function automatic void number_runs(int unsigned w_use);
        int unsigned count;
        int unsigned frac;
        bit          in_run;
        count  = 0;
        in_run = 1'b0;
        for (int c = 0; c < GCR_MAX_WIDTH; c++)
        begin
            if (c < w_use && column_marked[c])
            begin
                if (!in_run)
                begin
                    count++;
                    in_run = 1'b1;
                end
                column_in_run[c] = 1'b1;
                column_run[c]    = 8'(count - 1);
            end
            else
            begin
                in_run           = 1'b0;
                column_in_run[c] = 1'b0;
            end
        end
        run_total    = count;
        frac         = (reveal_reg > 11'd1024) ? 1024 : reveal_reg;
        runs_visible = (frac >= REVEAL_SHOW_ALL) ? count : (count * frac) >> 10;
    endfunction

    function automatic reveal_result_t predict_reveal(func_t fn, logic [7:0] x,
                                                      logic [7:0] y, logic [31:0] px);
        reveal_result_t res;
        int unsigned    w_use;
        int unsigned    h_use;
        logic [31:0]    stored;
        w_use = (width_reg > GCR_MAX_WIDTH) ? GCR_MAX_WIDTH : width_reg;
        h_use = (height_reg > GCR_MAX_HEIGHT) ? GCR_MAX_HEIGHT : height_reg;
        res   = '0;
        case (fn)
            FN_CLEAR:
                for (int c = 0; c < GCR_MAX_WIDTH; c++)
                    column_marked[c] = 1'b0;
            FN_FINISH:
                number_runs(w_use);
            default:
                if (x >= w_use || y >= h_use)
                    res.bad = 1'b1;
                else if (fn == FN_WRITE)
                begin
                    frame_copy[{y, x}] = px;
                    if (px[31:24] > GCR_ALPHA_THRESHOLD)
                        column_marked[x] = 1'b1;
                end
                else
                begin
                    stored = frame_copy[{y, x}];
                    if (column_in_run[x] && column_run[x] >= runs_visible
                        && stored[31:24] > GCR_ALPHA_THRESHOLD)
                        stored = '0;
                    res.pixel = stored;
                end
        endcase
        res.total   = run_total[7:0];
        res.shown   = runs_visible[7:0];
        res.changed = (runs_visible < run_total);
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reveal_result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            for (int c = 0; c < GCR_MAX_WIDTH; c++)
            begin
                column_marked[c] = 1'b0;
                column_in_run[c] = 1'b0;
                column_run[c]    = '0;
            end
            run_total    = 0;
            runs_visible = 0;
            width_reg    = 9'd256;
            height_reg   = 9'd256;
            reveal_reg   = 11'd1024;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_IMAGE_WIDTH:     width_reg  = cfg_data[8:0];
                    CFG_IMAGE_HEIGHT:    height_reg = cfg_data[8:0];
                    CFG_REVEAL_FRACTION: reveal_reg = cfg_data;
                    default: ;
                endcase

            // a request and the previous result may share one edge; predict first
            if (item_valid && !item_stall)
                expected_results = {expected_results,
                                    predict_reveal(func_t'(func), pos_x, pos_y, pixel_in)};

            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result expected none actual pixel %h", $time, pixel_out);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("pixel_out", want.pixel, pixel_out);
                    check_field("group_total", 32'(want.total), 32'(group_total));
                    check_field("groups_shown", 32'(want.shown), 32'(groups_shown));
                    check_field("frame_changed", 32'(want.changed), 32'(frame_changed));
                    check_field("bad_position", 32'(want.bad), 32'(bad_position));
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule : glyph_reveal_monitor

/* tb/sv/glyph_column_reveal_mask_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_column_reveal_mask_tb
// Self-checking bench for the glyph column reveal mask: directed frames for
// thresholds, stale numbering and size limits, then random scenes of
// configure / clear / write runs / finish / read, with bursty requests and a
// stalling result side. Checking lives in glyph_reveal_monitor.
// ----------------------------------------------------------------------------
module glyph_column_reveal_mask_tb;
    import gcr_pkg::*;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_we       = 1'b0;
    logic [1:0]  cfg_index    = CFG_IMAGE_WIDTH;
    logic [10:0] cfg_data     = '0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    logic [1:0]  func         = FN_CLEAR;
    logic [7:0]  pos_x        = '0;
    logic [7:0]  pos_y        = '0;
    logic [31:0] pixel_in     = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] pixel_out;
    logic [7:0]  group_total;
    logic [7:0]  groups_shown;
    logic        frame_changed;
    logic        bad_position;

    int          mismatch_count;
    int          outstanding;

    // size in use as the block sees it, for picking good and bad positions
    int unsigned width_use  = GCR_MAX_WIDTH;
    int unsigned height_use = GCR_MAX_HEIGHT;
    int unsigned burst_left = 0;
    int unsigned sent_count = 0;

    // frame entries written so far; in-range reads only ever target these
    bit          pixel_written [0:GCR_MAX_WIDTH*GCR_MAX_HEIGHT-1];
    logic [15:0] written_addrs[$];

    stall_mode_t stall_mode = STALL_NONE;
    int unsigned stall_span = 0;
    int unsigned cycle_ctr  = 0;

    glyph_column_reveal_mask dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .func          (func),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pixel_in      (pixel_in),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .pixel_out     (pixel_out),
        .group_total   (group_total),
        .groups_shown  (groups_shown),
        .frame_changed (frame_changed),
        .bad_position  (bad_position)
    );

    glyph_reveal_monitor reveal_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .func           (func),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pixel_in       (pixel_in),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .pixel_out      (pixel_out),
        .group_total    (group_total),
        .groups_shown   (groups_shown),
        .frame_changed  (frame_changed),
        .bad_position   (bad_position),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Result side: stall pattern switches mode after a random span, so
    // there are quiet stretches as well as heavy back-pressure.
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_span <= $urandom_range(16, 160);
        end
        else
            stall_span <= stall_span - 1;
        cycle_ctr <= cycle_ctr + 1;
        case (stall_mode)
            STALL_NONE:     result_stall <= 1'b0;
            STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: result_stall <= ((cycle_ctr % 8) >= 5);
            default:        result_stall <= 1'b0;
        endcase
    end

    // Hand one request over and wait for its accept edge. Valid stays high on
    // return; whatever comes next either reloads the payload in the same step
    // or drops valid.
    task automatic send(func_t fn, logic [7:0] x, logic [7:0] y, logic [31:0] px);
        int unsigned pause;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            pause      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (pause != 0)
            begin
                item_valid <= 1'b0;
                repeat (pause) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        func       <= fn;
        pos_x      <= x;
        pos_y      <= y;
        pixel_in   <= px;
        do @(posedge clk); while (item_stall);
        sent_count++;
        if (fn == FN_WRITE && x < width_use && y < height_use && !pixel_written[{y, x}])
        begin
            pixel_written[{y, x}] = 1'b1;
            written_addrs = {written_addrs, {y, x}};
        end
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // All three registers, back to back, only once the block is idle.
    // Width and height carry random junk in the unused top bits.
    task automatic set_registers(int unsigned w, int unsigned h, int unsigned r);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= {2'($urandom), 9'(w)};
        @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= {2'($urandom), 9'(h)};
        @(posedge clk);
        cfg_index <= CFG_REVEAL_FRACTION;
        cfg_data  <= 11'(r);
        @(posedge clk);
        cfg_we     <= 1'b0;
        width_use  = (w > GCR_MAX_WIDTH) ? GCR_MAX_WIDTH : w;
        height_use = (h > GCR_MAX_HEIGHT) ? GCR_MAX_HEIGHT : h;
    endtask

    // Position outside the size in use; skipped when the full frame is in use.
    task automatic send_bad(func_t fn);
        if (width_use < GCR_MAX_WIDTH)
            send(fn, 8'($urandom_range(width_use, 255)), 8'($urandom), $urandom);
        else if (height_use < GCR_MAX_HEIGHT)
            send(fn, 8'($urandom), 8'($urandom_range(height_use, 255)), $urandom);
    endtask

    // Read back a pixel written earlier that is still inside the frame, else a bad one.
    task automatic read_written();
        logic [15:0] a;
        for (int tries = 0; tries < 16 && written_addrs.size() != 0; tries++)
        begin
            a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
            if (a[7:0] < width_use && a[15:8] < height_use)
            begin
                send(FN_READ, a[7:0], a[15:8], $urandom);
                return;
            end
        end
        send_bad(FN_READ);
    endtask

    // Stray request dropped into an otherwise well-formed scene.
    task automatic noise();
        case ($urandom_range(0, 3))
            0:       send(FN_CLEAR, 8'($urandom), 8'($urandom), $urandom);
            1:       send(FN_WRITE, 8'($urandom), 8'($urandom), $urandom);
            2:       send(FN_FINISH, 8'($urandom), 8'($urandom), $urandom);
            default: read_written();
        endcase
    endtask

    // Sizes: mostly mid-range, with 1, full, saturating and zero mixed in.
    function automatic int unsigned pick_size();
        case ($urandom_range(0, 19))
            0, 1:    return 1;
            2, 3:    return 256;
            4, 5:    return $urandom_range(257, 511);
            6:       return 0;
            default: return $urandom_range(16, 255);
        endcase
    endfunction

    function automatic int unsigned pick_reveal();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1022;
            2:       return 1023;
            3:       return 1024;
            4:       return $urandom_range(1025, 2047);
            default: return $urandom_range(0, 1024);
        endcase
    endfunction

    // Alpha around the threshold often, fully random otherwise.
    function automatic logic [31:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return {8'($urandom_range(0, 8)), 24'($urandom)};
            1:       return {8'd9, 24'($urandom)};
            2:       return {8'd255, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Mostly rows in range; now and then any row, which may be out of range.
    function automatic logic [7:0] pick_row();
        if (height_use == 0 || $urandom_range(0, 9) == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, height_use - 1));
    endfunction

    initial
    begin
        bit          comb;
        int unsigned runs;
        int unsigned start;
        int unsigned len;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ------------------------------------------------------
        // status before any finish, then a finish that finds nothing
        send(FN_CLEAR, 8'd0, 8'd0, 32'h0);
        send(FN_FINISH, 8'd0, 8'd0, 32'h0);
        // alpha at threshold does not mark; one above does; corners of frame
        send(FN_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send(FN_WRITE, 8'd1, 8'd0, 32'h08FF_FFFF);
        send(FN_WRITE, 8'd3, 8'd7, 32'h0900_0000);
        send(FN_WRITE, 8'd255, 8'd255, 32'h80A5_A5A5);
        send(FN_WRITE, 8'd254, 8'd255, 32'h0000_0000);
        send(FN_FINISH, 8'd0, 8'd0, 32'h0);
        // half of three runs: only the leftmost stays
        set_registers(256, 256, 512);
        send(FN_FINISH, 8'd0, 8'd0, 32'h0);
        send(FN_READ, 8'd0, 8'd0, 32'h0);
        send(FN_READ, 8'd1, 8'd0, 32'h0);
        send(FN_READ, 8'd3, 8'd7, 32'h0);
        send(FN_READ, 8'd255, 8'd255, 32'h0);
        send(FN_READ, 8'd254, 8'd255, 32'h0);
        // low alpha overwrite keeps the mark; clear keeps the old numbering
        send(FN_WRITE, 8'd0, 8'd0, 32'h0012_3456);
        send(FN_CLEAR, 8'd0, 8'd0, 32'h0);
        send(FN_READ, 8'd0, 8'd0, 32'h0);
        send(FN_READ, 8'd3, 8'd7, 32'h0);
        send(FN_FINISH, 8'd0, 8'd0, 32'h0);
        // zero width: every position is bad
        set_registers(0, 256, 0);
        send(FN_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send(FN_READ, 8'd0, 8'd0, 32'h0);
        // saturating width, one row, reveal above one
        set_registers(300, 1, 2047);
        send(FN_WRITE, 8'd5, 8'd0, 32'hFF00_0000);
        send(FN_WRITE, 8'd5, 8'd1, 32'hFF00_0000);
        send(FN_FINISH, 8'd0, 8'd0, 32'h0);
        // just at and just below the show-all point
        set_registers(256, 256, 1023);
        send(FN_WRITE, 8'd200, 8'd3, 32'hFF12_3456);
        send(FN_FINISH, 8'd0, 8'd0, 32'h0);
        set_registers(256, 256, 1022);
        send(FN_FINISH, 8'd0, 8'd0, 32'h0);
        send(FN_READ, 8'd200, 8'd3, 32'h0);

        // ---- random scenes -------------------------------------------------
        // configure, clear, write clustered column runs, finish, read back
        while (sent_count < 1300)
        begin
            comb = ($urandom_range(0, 14) == 0);
            set_registers(comb ? 256 : pick_size(), pick_size(), pick_reveal());
            if ($urandom_range(0, 7) != 0)
                send(FN_CLEAR, 8'($urandom), 8'($urandom), $urandom);
            if (comb)
            begin
                // every other column: the largest possible run count
                for (int c = 0; c < GCR_MAX_WIDTH; c += 2)
                    send(FN_WRITE, 8'(c), pick_row(), {8'($urandom_range(9, 255)),
                                                      24'($urandom)});
            end
            else
            begin
                runs = $urandom_range(1, 8);
                repeat (runs)
                begin
                    start = (width_use == 0 || $urandom_range(0, 9) == 0)
                            ? $urandom_range(0, 255) : $urandom_range(0, width_use - 1);
                    len   = $urandom_range(1, 6);
                    for (int c = 0; c < len && start + c < GCR_MAX_WIDTH; c++)
                        repeat ($urandom_range(1, 2))
                            send(FN_WRITE, 8'(start + c), pick_row(), pick_pixel());
                end
            end
            repeat ($urandom_range(0, 2)) noise();
            send(FN_FINISH, 8'($urandom), 8'($urandom), $urandom);
            repeat ($urandom_range(4, 20))
            begin
                case ($urandom_range(0, 9))
                    0:       send_bad(FN_READ);
                    1:       noise();
                    default: read_written();
                endcase
            end
        end

        // let the last results come home, then watch for strays
        drain();
        repeat (GCR_MAX_WIDTH + 2) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("glyph_column_reveal_mask regression: pass");
        else
            $display("glyph_column_reveal_mask regression: fail");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("glyph_column_reveal_mask regression: fail");
        $finish;
    end

endmodule : glyph_column_reveal_mask_tb

/* glyph_column_reveal_mask.f */
rtl/gcr_pkg.sv
rtl/gcr_frame_mem.sv
rtl/gcr_seg.sv
rtl/glyph_column_reveal_mask.sv
rtl/gcr_checker.sv
tb/sv/glyph_reveal_monitor.sv
tb/sv/glyph_column_reveal_mask_tb.sv
